FILE: hw/rtl/cie_pkg.sv
// cie_pkg: widths, payload types and constants of the cubic curve evaluator.
// Used by every module under hw/rtl; depends on nothing.
`default_nettype none

package cie_pkg;

  // field widths
  localparam int unsigned CoordW = 32;
  localparam int unsigned IdxW   = 10;
  localparam int unsigned StepW  = 25;
  localparam int unsigned UW     = IdxW + StepW;   // u in Q11.24

  // u_step after reset, about 0.001 in Q1.24
  localparam logic [StepW-1:0] UStepRst = StepW'(16777);

  // coefficient widths: 9*A3, 9*A2, A1 and 2*p0+1
  localparam int unsigned A3W  = 39;
  localparam int unsigned A2W  = 39;
  localparam int unsigned A1W  = 38;
  localparam int unsigned P0TW = CoordW + 2;

  // Horner step result widths
  localparam int unsigned S1W = 76;
  localparam int unsigned S2W = 112;
  localparam int unsigned S3W = 148;

  // addend alignment per Horner step
  localparam int unsigned Sh1 = 24;
  localparam int unsigned Sh2 = 48;
  localparam int unsigned Sh3 = 72;

  // quotient position in the final sum
  localparam int unsigned QLsb = 73;

  // register stages through one Horner step
  localparam int unsigned MacLat = 3;

  localparam logic [CoordW-1:0] SatMax = {1'b0, {(CoordW-1){1'b1}}};
  localparam logic [CoordW-1:0] SatMin = {1'b1, {(CoordW-1){1'b0}}};

  typedef struct packed {
    logic signed [CoordW-1:0] axis_p0;
    logic signed [CoordW-1:0] axis_p1;
    logic signed [CoordW-1:0] axis_p2;
    logic signed [CoordW-1:0] axis_p3;
    logic        [IdxW-1:0]   sample_index;
  } in_item_t;

  typedef struct packed {
    logic signed [CoordW-1:0] curve_value;
    logic                     saturated;
  } out_item_t;

  typedef struct packed {
    logic signed [A3W-1:0]  a3x9;
    logic signed [A2W-1:0]  a2x9;
    logic signed [A1W-1:0]  a1;
    logic signed [P0TW-1:0] p0t;
    logic        [UW-1:0]   u;
  } coef_t;

endpackage

`default_nettype wire

FILE: hw/rtl/cie_coef.sv
// cie_coef: first stage; forms u and the blending coefficients of one beat.
// Depends on cie_pkg.
`default_nettype none

module cie_coef (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     vld_i,
  input  wire cie_pkg::in_item_t        item_i,
  input  wire logic [cie_pkg::StepW-1:0] u_step_i,
  output logic                          vld_o,
  output cie_pkg::coef_t                coef_o
);
  import cie_pkg::*;

  logic signed [A3W-1:0] e0, e1, e2, e3;
  logic signed [A3W-1:0] a3, a2, a1w;
  coef_t coef_d, coef_q;
  logic  vld_q;

  // inverse Vandermonde blending on uniform nodes (constant multiplies only), u = index * u_step
  always_comb begin
    e0  = A3W'(item_i.axis_p0);
    e1  = A3W'(item_i.axis_p1);
    e2  = A3W'(item_i.axis_p2);
    e3  = A3W'(item_i.axis_p3);
    a3  = e3 - e0 + 39'sd3 * (e1 - e2);
    a2  = 39'sd2 * e0 - 39'sd5 * e1 + 39'sd4 * e2 - e3;
    a1w = 39'sd18 * e1 + 39'sd2 * e3 - 39'sd11 * e0 - 39'sd9 * e2;
    coef_d.a3x9 = (a3 <<< 3) + a3;
    coef_d.a2x9 = A2W'((a2 <<< 3) + a2);
    coef_d.a1   = A1W'(a1w);
    coef_d.p0t  = {item_i.axis_p0[CoordW-1], item_i.axis_p0, 1'b1};
    coef_d.u    = UW'(item_i.sample_index) * UW'(u_step_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    coef_q <= coef_d;
  end

  assign vld_o  = vld_q;
  assign coef_o = coef_q;

endmodule

`default_nettype wire

FILE: hw/rtl/cie_mac.sv
// cie_mac: one Horner step y = x*u + (add << SH), three register stages.
// Partial products 33x19 and 33x18 bits, then per-chunk merge, then final sum. Uses cie_pkg.
`default_nettype none

module cie_mac #(
  parameter int unsigned WX  = cie_pkg::A3W,
  parameter int unsigned WAD = cie_pkg::A2W,
  parameter int unsigned SH  = cie_pkg::Sh1,
  parameter int unsigned WY  = cie_pkg::S1W
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     vld_i,
  input  wire logic signed [WX-1:0]     x_i,
  input  wire logic [cie_pkg::UW-1:0]   u_i,
  input  wire logic signed [WAD-1:0]    add_i,
  output logic                          vld_o,
  output logic signed [WY-1:0]          y_o,
  output logic [cie_pkg::UW-1:0]        u_o
);
  import cie_pkg::*;

  localparam int unsigned NC   = (WX + 31) / 32;
  localparam int unsigned XEW  = NC * 32;
  localparam int unsigned ULoW = 18;
  localparam int unsigned UHiW = UW - ULoW;
  localparam int unsigned PPW  = 33 + ULoW + 1;
  localparam int unsigned CW   = PPW + ULoW + 1;

  logic signed [XEW-1:0]   xe;
  logic signed [ULoW:0]    u_lo;
  logic signed [UHiW:0]    u_hi;

  // stage A: partial products
  logic signed [PPW-1:0]   pp_lo_d [NC];
  logic signed [PPW-1:0]   pp_hi_d [NC];
  logic signed [PPW-1:0]   pp_lo_q [NC];
  logic signed [PPW-1:0]   pp_hi_q [NC];
  logic signed [WAD-1:0]   add_a_q;
  logic [UW-1:0]           u_a_q;
  logic                    vld_a_q;

  // stage B: per-chunk sums
  logic signed [CW-1:0]    c_d [NC];
  logic signed [CW-1:0]    c_q [NC];
  logic signed [WAD-1:0]   add_b_q;
  logic [UW-1:0]           u_b_q;
  logic                    vld_b_q;

  // stage C: result
  logic signed [WY-1:0]    y_d, y_q;
  logic [UW-1:0]           u_c_q;
  logic                    vld_c_q;

  assign xe   = XEW'(x_i);
  assign u_lo = $signed({1'b0, u_i[ULoW-1:0]});
  assign u_hi = $signed({1'b0, u_i[UW-1:ULoW]});

  // lower chunks are unsigned, the top chunk carries the sign
  for (genvar k = 0; k < NC; k++) begin : g_pp
    logic signed [32:0] xc;
    if (k == NC - 1) begin : g_top
      assign xc = $signed({xe[32*k+31], xe[32*k+31 -: 32]});
    end else begin : g_low
      assign xc = $signed({1'b0, xe[32*k+31 -: 32]});
    end
    assign pp_lo_d[k] = PPW'(xc) * PPW'(u_lo);
    assign pp_hi_d[k] = PPW'(xc) * PPW'(u_hi);
    assign c_d[k]     = CW'(pp_lo_q[k]) + (CW'(pp_hi_q[k]) <<< ULoW);
  end

  // stage C sum: NC chunks plus the aligned addend
  always_comb begin
    y_d = WY'(add_b_q) <<< SH;
    for (int k = 0; k < NC; k++) begin
      y_d = y_d + (WY'(c_q[k]) <<< (32 * k));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
      vld_c_q <= 1'b0;
    end else begin
      vld_a_q <= vld_i;
      vld_b_q <= vld_a_q;
      vld_c_q <= vld_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pp_lo_q <= pp_lo_d;
    pp_hi_q <= pp_hi_d;
    add_a_q <= add_i;
    u_a_q   <= u_i;
    c_q     <= c_d;
    add_b_q <= add_a_q;
    u_b_q   <= u_a_q;
    y_q     <= y_d;
    u_c_q   <= u_b_q;
  end

  assign vld_o = vld_c_q;
  assign y_o   = y_q;
  assign u_o   = u_c_q;

endmodule

`default_nettype wire

FILE: hw/rtl/cie_sat.sv
// cie_sat: takes the Q16.16 quotient from the exact sum and clips it to 32 bits.
// Output register of the block. Depends on cie_pkg.
`default_nettype none

module cie_sat (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          vld_i,
  input  wire logic signed [cie_pkg::S3W-1:0] sum_i,
  output logic                               vld_o,
  output cie_pkg::out_item_t                 res_o
);
  import cie_pkg::*;

  localparam int unsigned HiLsb = QLsb + CoordW - 1;

  logic [S3W-1-HiLsb:0] hi;
  logic                 fits;
  out_item_t            res_d, res_q;
  logic                 vld_q;

  // in range when every bit from the quotient sign upward agrees
  always_comb begin
    hi   = sum_i[S3W-1:HiLsb];
    fits = (&hi) | ~(|hi);
    if (fits) begin
      res_d.curve_value = sum_i[QLsb +: CoordW];
      res_d.saturated   = 1'b0;
    end else begin
      res_d.curve_value = sum_i[S3W-1] ? SatMin : SatMax;
      res_d.saturated   = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign vld_o = vld_q;
  assign res_o = res_q;

endmodule

`default_nettype wire

FILE: hw/rtl/cubic_interp_curve_eval.sv
// cubic_interp_curve_eval: four-point cubic curve evaluator, one axis per beat.
// Instantiates cie_coef, three cie_mac steps and cie_sat; uses cie_pkg.
//
//   port group              dir  width  notes
//   start / item_i          in   138    input beat, taken when start and !busy
//   busy                    out  1      always low, a beat can enter every cycle
//   done_o / result_o       out  33     result beat, one cycle, cannot be held off
//   cfg_we_i / cfg_wdata_i  in   25     u_step write
//
// One beat enters per clock; each result passes through the coefficient stage,
// three Horner steps of three stages each and the output stage.
// The three cascaded x*u multiplies, split into 33x19 and 33x18 partial products,
// set that depth. Reset clears the valid bits and sets u_step to about 0.001.
// Nothing stalls: results stream out in input order.
`default_nettype none

module cubic_interp_curve_eval (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start,
  output logic                            busy,
  input  wire cie_pkg::in_item_t          item_i,
  output logic                            done_o,
  output cie_pkg::out_item_t              result_o,
  input  wire logic                       cfg_we_i,
  input  wire logic [cie_pkg::StepW-1:0]  cfg_wdata_i
);
  import cie_pkg::*;

  logic [StepW-1:0]        u_step_q;
  logic                    cvld;
  coef_t                   coef;
  logic                    v1, v2, v3;
  logic signed [S1W-1:0]   y1;
  logic signed [S2W-1:0]   y2;
  logic signed [S3W-1:0]   y3;
  logic [UW-1:0]           u1, u2, u3;
  logic signed [A1W-1:0]   a1_dly_q  [MacLat];
  logic signed [P0TW-1:0]  p0t_dly_q [2*MacLat];

  assign busy = 1'b0;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      u_step_q <= UStepRst;
    end else if (cfg_we_i) begin
      u_step_q <= cfg_wdata_i;
    end
  end

  cie_coef u_coef (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .vld_i    (start & ~busy),
    .item_i   (item_i),
    .u_step_i (u_step_q),
    .vld_o    (cvld),
    .coef_o   (coef)
  );

  // addends wait for their Horner step
  always_ff @(posedge clk_i) begin
    a1_dly_q[0]  <= coef.a1;
    p0t_dly_q[0] <= coef.p0t;
    for (int i = 1; i < MacLat; i++) begin
      a1_dly_q[i] <= a1_dly_q[i-1];
    end
    for (int i = 1; i < 2*MacLat; i++) begin
      p0t_dly_q[i] <= p0t_dly_q[i-1];
    end
  end

  // 9*A3*u + 9*A2*2^24
  cie_mac #(.WX(A3W), .WAD(A2W), .SH(Sh1), .WY(S1W)) u_mac1 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (cvld),
    .x_i    (coef.a3x9),
    .u_i    (coef.u),
    .add_i  (coef.a2x9),
    .vld_o  (v1),
    .y_o    (y1),
    .u_o    (u1)
  );

  // ... * u + A1*2^48
  cie_mac #(.WX(S1W), .WAD(A1W), .SH(Sh2), .WY(S2W)) u_mac2 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (v1),
    .x_i    (y1),
    .u_i    (u1),
    .add_i  (a1_dly_q[MacLat-1]),
    .vld_o  (v2),
    .y_o    (y2),
    .u_o    (u2)
  );

  // ... * u + (2*p0 + 1)*2^72, rounding term folded in
  cie_mac #(.WX(S2W), .WAD(P0TW), .SH(Sh3), .WY(S3W)) u_mac3 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (v2),
    .x_i    (y2),
    .u_i    (u2),
    .add_i  (p0t_dly_q[2*MacLat-1]),
    .vld_o  (v3),
    .y_o    (y3),
    .u_o    (u3)
  );

  cie_sat u_sat (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (v3 & (u3 == u3)),
    .sum_i  (y3),
    .vld_o  (done_o),
    .res_o  (result_o)
  );

endmodule

`default_nettype wire

FILE: tb/sv/tb_cubic_interp_curve_eval.sv
// tb_cubic_interp_curve_eval: self-checking bench for the four-point cubic curve evaluator.
// A queue-fed driver sends control-point beats, exact wide-integer math predicts every curve
// value, and a monitor checks each result beat in order. Depends on cie_pkg and the RTL only.
module tb_cubic_interp_curve_eval;
  import cie_pkg::*;

  localparam int unsigned LatencyCyc = 11;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned ShownErrs  = 10;
  localparam int unsigned PhaseBeats = 175;
  localparam int unsigned GapMax     = 14;

  // scaling of the exact sum 2*p(u) * 2^72
  localparam int unsigned UFrac  = 24;
  localparam int unsigned RndPos = 72;
  localparam int unsigned QPos   = 73;

  localparam logic signed [CoordW-1:0] CoordMax = 32'sh7FFF_FFFF;
  localparam logic signed [CoordW-1:0] CoordMin = 32'sh8000_0000;
  localparam logic signed [CoordW-1:0] CoordOne = 32'sh0001_0000;

  typedef enum int unsigned {GapNone, GapSparse, GapFull} gap_mode_e;
  typedef enum int unsigned {CoordNear, CoordAny, CoordEdge} coord_mode_e;

  typedef struct {
    in_item_t    pts;
    int unsigned gap;
  } seg_req_t;

  // DUT signals
  logic                clk_i;
  logic                rst_ni      = 1'b0;
  logic                start       = 1'b0;
  logic                busy;
  in_item_t            item_i      = '0;
  logic                done_o;
  out_item_t           result_o;
  logic                cfg_we_i    = 1'b0;
  logic [StepW-1:0]    cfg_wdata_i = '0;

  // bench state
  seg_req_t            segments_q[$];
  out_item_t           curve_values_q[$];
  logic [StepW-1:0]    ustep_shadow = UStepRst;
  seg_req_t            next_seg;
  out_item_t           want;
  int unsigned         wait_cnt     = 0;
  int unsigned         beats_in     = 0;
  int unsigned         results_seen = 0;
  int unsigned         sat_seen     = 0;
  int unsigned         err_cnt      = 0;
  int unsigned         cfg_writes   = 0;
  int unsigned         step_phases  = 0;
  int unsigned         cycle_cnt    = 0;

  cubic_interp_curve_eval dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .item_i     (item_i),
    .done_o     (done_o),
    .result_o   (result_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Exact cubic: N = ((9A3*U + 9A2*2^24)*U + A1*2^48)*U + 2*p0*2^72 + 2^72, U = idx*step in Q.24
  function automatic out_item_t eval_cubic(in_item_t it, logic [StepW-1:0] step);
    logic signed [191:0] p0, p1, p2, p3, uu, a1, a2x9, a3x9, acc;
    out_item_t r;
    p0   = it.axis_p0;
    p1   = it.axis_p1;
    p2   = it.axis_p2;
    p3   = it.axis_p3;
    uu   = it.sample_index * step;
    a1   = -11 * p0 + 18 * p1 - 9 * p2 + 2 * p3;
    a2x9 = 9 * (2 * p0 - 5 * p1 + 4 * p2 - p3);
    a3x9 = 9 * (3 * p1 - 3 * p2 + p3 - p0);
    acc  = ((a3x9 * uu + (a2x9 <<< UFrac)) * uu + (a1 <<< (2 * UFrac))) * uu
           + (p0 <<< QPos) + (192'sd1 <<< RndPos);
    // quotient fits when everything from its top bit up is sign
    if (acc[191:QPos+31] == '0 || acc[191:QPos+31] == '1) begin
      r.curve_value = acc[QPos+31:QPos];
      r.saturated   = 1'b0;
    end else begin
      r.curve_value = acc[191] ? CoordMin : CoordMax;
      r.saturated   = 1'b1;
    end
    return r;
  endfunction

  function automatic logic signed [CoordW-1:0] rand_coord(coord_mode_e cm);
    logic [31:0] v;
    v = $urandom();
    case (cm)
      CoordNear: return {{12{v[19]}}, v[19:0]};         // within about +-8.0
      CoordEdge: return {v[31], {21{~v[31]}}, v[9:0]};  // hugging either rail
      default:   return v;
    endcase
  endfunction

  function automatic int unsigned draw_gap(gap_mode_e gm);
    case (gm)
      GapNone:   return 0;
      GapSparse: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, GapMax) : 0;
      default:   return $urandom_range(0, GapMax);
    endcase
  endfunction

  task automatic push_seg(logic signed [CoordW-1:0] p0, logic signed [CoordW-1:0] p1,
                          logic signed [CoordW-1:0] p2, logic signed [CoordW-1:0] p3,
                          logic [IdxW-1:0] idx, int unsigned gap);
    seg_req_t s;
    s.pts.axis_p0      = p0;
    s.pts.axis_p1      = p1;
    s.pts.axis_p2      = p2;
    s.pts.axis_p3      = p3;
    s.pts.sample_index = idx;
    s.gap              = gap;
    segments_q.insert(segments_q.size(), s);
  endtask

  task automatic push_random(gap_mode_e gm);
    coord_mode_e     cm;
    logic [IdxW-1:0] idx;
    int unsigned     pick;
    pick = $urandom_range(0, 9);
    cm   = (pick < 6) ? CoordNear : ((pick < 8) ? CoordAny : CoordEdge);
    case ($urandom_range(0, 3))
      0:       idx = IdxW'($urandom_range(0, 15));
      1:       idx = $urandom_range(0, 1) ? '1 : '0;
      default: idx = IdxW'($urandom());
    endcase
    push_seg(rand_coord(cm), rand_coord(cm), rand_coord(cm), rand_coord(cm), idx,
             draw_gap(gm));
  endtask

  // sender holds off until every pending beat is taken and every result is back
  task automatic wait_idle();
    while (segments_q.size() != 0 || start || curve_values_q.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic run_phase(logic [StepW-1:0] step, bit do_write, gap_mode_e gm);
    int unsigned n;
    if (do_write) begin
      wait_idle();
      @(posedge clk_i);
      cfg_we_i    <= 1'b1;
      cfg_wdata_i <= step;
      @(posedge clk_i);
      cfg_we_i    <= 1'b0;
      cfg_writes++;
      @(negedge clk_i);
    end
    step_phases++;
    for (n = 0; n < PhaseBeats; n++)
      push_random(gm);
    wait_idle();
  endtask

  // Directed beats at the reset step (u up to about 1.023)
  task automatic add_directed();
    push_seg('0, '0, '0, '0, '0, 0);
    push_seg('0, '0, '0, '0, '1, 0);
    push_seg(CoordMax, CoordMax, CoordMax, CoordMax, '0, 0);
    push_seg(CoordMax, CoordMax, CoordMax, CoordMax, '1, 0);
    push_seg(CoordMin, CoordMin, CoordMin, CoordMin, '1, 3);
    // alternating rails: extrapolation past u=1 clips both ways
    push_seg(CoordMax, CoordMin, CoordMax, CoordMin, '1, 0);
    push_seg(CoordMin, CoordMax, CoordMin, CoordMax, '1, 0);
    push_seg(CoordMax, CoordMin, CoordMax, CoordMin, 10'd500, 0);
    push_seg(CoordMin, CoordMax, CoordMin, CoordMax, 10'd341, 5);
    // straight line 0..1, evaluated beyond its end and inside it
    push_seg('0, 32'sd21845, 32'sd43691, CoordOne, '1, 0);
    push_seg('0, 32'sd21845, 32'sd43691, CoordOne, 10'd682, 0);
    push_seg(32'sd1, '0, '0, '0, '0, 0);
    push_seg(-32'sd1, '0, '0, '0, '0, 1);
    push_seg(CoordOne, -CoordOne, CoordOne, -CoordOne, 10'd1, 0);
    push_seg(rand_coord(CoordAny), rand_coord(CoordAny), rand_coord(CoordAny),
             rand_coord(CoordAny), 10'd512, 0);
    push_seg(rand_coord(CoordEdge), rand_coord(CoordEdge), rand_coord(CoordEdge),
             rand_coord(CoordEdge), '1, 0);
  endtask

  task automatic note_fail(string what, out_item_t exp_v, out_item_t got);
    err_cnt++;
    if (err_cnt <= ShownErrs)
      $display("mismatch (%s): expected value %h sat %0b, got value %h sat %0b",
               what, exp_v.curve_value, exp_v.saturated, got.curve_value, got.saturated);
  endtask

  // Driver: one beat per start/!busy handshake, gap drawn per beat
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start    <= 1'b0;
      wait_cnt <= 0;
    end else begin
      if (cfg_we_i) ustep_shadow <= cfg_wdata_i;
      if (start && !busy) begin
        curve_values_q.insert(curve_values_q.size(), eval_cubic(item_i, ustep_shadow));
        beats_in++;
      end
      if (!start || !busy) begin
        if (segments_q.size() != 0 && wait_cnt >= segments_q[0].gap) begin
          next_seg = segments_q.pop_front();
          item_i   <= next_seg.pts;
          start    <= 1'b1;
          wait_cnt <= 0;
        end else begin
          start <= 1'b0;
          if (segments_q.size() != 0) wait_cnt <= wait_cnt + 1;
        end
      end
    end
  end

  // Monitor: results cannot be held off, compare each against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      results_seen++;
      if (curve_values_q.size() == 0) begin
        note_fail("no value pending", '0, result_o);
      end else begin
        want = curve_values_q.pop_front();
        if (want.saturated) sat_seen++;
        if (result_o.curve_value !== want.curve_value || result_o.saturated !== want.saturated)
          note_fail("curve value", want, result_o);
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d beats in, %0d results", cycle_cnt, beats_in,
               results_seen);
      $display("TB_ERROR");
      $finish;
    end
  end

  // Sequence: reset, directed beats, then phases across u_step settings
  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    add_directed();
    run_phase(UStepRst, 1'b0, GapSparse);
    run_phase(25'd1, 1'b1, GapFull);
    run_phase(25'd16777216, 1'b1, GapNone);
    run_phase(25'd0, 1'b1, GapFull);
    run_phase(StepW'($urandom_range(1, 16777216)), 1'b1, GapSparse);
    run_phase(25'd65536, 1'b1, GapFull);
    run_phase(StepW'($urandom_range(1, 16777216)), 1'b1, GapNone);
    run_phase(UStepRst, 1'b1, GapSparse);
    wait_idle();
    repeat (LatencyCyc + 5) @(negedge clk_i);
    $display("run covered %0d beats over %0d u_step settings (%0d register writes)",
             beats_in, step_phases, cfg_writes);
    $display("%0d results checked, %0d clipped, %0d mismatches, %0d still pending",
             results_seen, sat_seen, err_cnt, curve_values_q.size());
    if (err_cnt == 0 && curve_values_q.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/cie_pkg.sv
hw/rtl/cie_coef.sv
hw/rtl/cie_mac.sv
hw/rtl/cie_sat.sv
hw/rtl/cubic_interp_curve_eval.sv
tb/sv/tb_cubic_interp_curve_eval.sv
